// File: rtl/core/raw_pkg.sv
// Shared types and constants for the RADIUS attribute walker.
package raw_pkg;

  localparam logic [1:0] KIND_ATTR = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  localparam logic [15:0] HDR_LEN = 16'd20;
  localparam logic [7:0]  VSA_ID  = 8'd26;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] vendor_id;
    logic [7:0]  attr_id;
    logic [7:0]  attr_length;
    logic [15:0] value_offset;
    logic        run_last;
  } raw_res_t;

  // Results produced by one byte, handed to the result queue.
  typedef struct packed {
    logic [1:0] cnt;
    raw_res_t   res0;
    raw_res_t   res1;
  } raw_push_t;

endpackage

// File: rtl/core/raw_in_if.sv
// Byte input channel interface.
interface raw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, data_byte, first_byte, input ready);
  modport sink (input valid, data_byte, first_byte, output ready);
endinterface

// File: rtl/core/raw_out_if.sv
// Result channel interface.
interface raw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] vendor_id;
  logic [7:0]  attr_id;
  logic [7:0]  attr_length;
  logic [15:0] value_offset;
  logic        run_last;

  modport source (output valid, kind, vendor_id, attr_id, attr_length, value_offset,
                  run_last, input ready);
  modport sink (input valid, kind, vendor_id, attr_id, attr_length, value_offset,
                run_last, output ready);
endinterface

// File: rtl/core/radius_attribute_walker.sv
// Top level of the byte-serial RADIUS attribute walker.
//
//   channel  dir  beat
//   in_ch    in   one packet byte, first_byte marks packet offset 0
//   out_ch   out  one result: attribute, packet ok or packet malformed
//
// One byte is taken per cycle unless input stalls; it is held in the input register and
// its results (zero, one or two) land in a four-entry result queue.
// Input stalls only while the queue holds more than two results.
// rst_n is synchronous; it empties the queue and idles the parser until a
// first byte arrives.
module radius_attribute_walker
  import raw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  raw_in_if.sink    in_ch,
  raw_out_if.source out_ch
);

  raw_push_t push;
  logic      room;

  raw_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  raw_res_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

// File: rtl/core/raw_core.sv
// Input register and per-byte header/attribute parse state.
module raw_core
  import raw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  raw_in_if.sink     in_ch,
  input  logic       room,
  output raw_push_t  push
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_ATTR   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        in_first_r;

  logic [15:0] bp_r, bp_nxt;
  logic [15:0] tl_r, tl_nxt;
  logic [15:0] br_r, br_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  aid_r, aid_nxt;
  logic [7:0]  alen_r, alen_nxt;
  logic [31:0] vacc_r, vacc_nxt;
  logic [7:0]  sid_r, sid_nxt;

  logic        take;
  logic        active;
  logic        vsa;
  logic        bad;
  logic        do_rep;
  logic [31:0] rep_vend;
  logic [7:0]  rep_id;
  logic [7:0]  rep_len;
  logic [7:0]  rep_skip;
  logic [7:0]  b;
  logic [1:0]  n;
  raw_res_t    r0, r1;

  assign take = in_vld_r && room;
  assign in_ch.ready = !in_vld_r || room;
  assign b = in_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r  <= in_ch.data_byte;
      in_first_r <= in_ch.first_byte;
    end
  end

  always_comb begin
    bp_nxt   = bp_r;
    tl_nxt   = tl_r;
    br_nxt   = br_r;
    ph_nxt   = ph_r;
    idx_nxt  = idx_r;
    aid_nxt  = aid_r;
    alen_nxt = alen_r;
    vacc_nxt = vacc_r;
    sid_nxt  = sid_r;
    n        = 2'd0;
    r0       = '0;
    r1       = '0;
    active   = 1'b0;
    bad      = 1'b0;
    do_rep   = 1'b0;
    rep_vend = '0;
    rep_id   = '0;
    rep_len  = '0;
    rep_skip = '0;
    vsa      = (aid_r == VSA_ID);
    if (take) begin
      active = 1'b1;
      if (in_first_r) begin
        bp_nxt   = '0;
        tl_nxt   = '0;
        br_nxt   = '0;
        ph_nxt   = PH_HEADER;
        idx_nxt  = '0;
        aid_nxt  = '0;
        alen_nxt = '0;
        vacc_nxt = '0;
        sid_nxt  = '0;
      end else if (ph_r == PH_IDLE || ph_r == PH_DONE) begin
        active = 1'b0;
      end else begin
        bp_nxt = 16'(bp_r + 16'd1);
      end
    end
    if (active) begin
      if (ph_nxt == PH_HEADER) begin
        if (bp_nxt == 16'd2) begin
          tl_nxt = {b, 8'h00};
        end else if (bp_nxt == 16'd3) begin
          tl_nxt = {tl_r[15:8], b};
          if (tl_nxt < HDR_LEN) begin
            bad = 1'b1;
          end
        end else if (bp_nxt == HDR_LEN - 16'd1) begin
          br_nxt = 16'(tl_r - HDR_LEN);
          if (br_nxt < 16'd2) begin
            r0.kind     = KIND_OK;
            r0.run_last = 1'b1;
            n           = 2'd1;
            ph_nxt      = PH_DONE;
          end else begin
            ph_nxt  = PH_ATTR;
            idx_nxt = '0;
          end
        end
      end else if (idx_r == 8'd0) begin
        aid_nxt = b;
        idx_nxt = 8'd1;
      end else if (idx_r == 8'd1) begin
        alen_nxt = b;
        if (br_r < {8'h00, b} || b < 8'd2) begin
          bad = 1'b1;
        end else begin
          br_nxt = 16'(br_r - {8'h00, b});
          if (!vsa) begin
            do_rep   = 1'b1;
            rep_vend = '0;
            rep_id   = aid_r;
            rep_len  = b;
            rep_skip = 8'd2;
          end else if (b < 8'd8) begin
            bad = 1'b1;
          end else begin
            vacc_nxt = '0;
            idx_nxt  = 8'd2;
          end
        end
      end else if (vsa && idx_r < 8'd8) begin
        if (idx_r <= 8'd5) begin
          vacc_nxt = {vacc_r[23:0], b};
          idx_nxt  = 8'(idx_r + 8'd1);
        end else if (idx_r == 8'd6) begin
          sid_nxt = b;
          idx_nxt = 8'd7;
        end else if (b != 8'(alen_r - 8'd6)) begin
          bad = 1'b1;
        end else begin
          do_rep   = 1'b1;
          rep_vend = vacc_r;
          rep_id   = sid_r;
          rep_len  = b;
          rep_skip = 8'd8;
        end
      end else if (({1'b0, idx_r} + 9'd1) >= {1'b0, alen_r}) begin
        // last value byte of this attribute
        idx_nxt = '0;
      end else begin
        idx_nxt = 8'(idx_r + 8'd1);
      end

      if (bad) begin
        r0.kind     = KIND_BAD;
        r0.run_last = 1'b1;
        n           = 2'd1;
        ph_nxt      = PH_DONE;
      end else if (do_rep) begin
        r0.kind         = KIND_ATTR;
        r0.vendor_id    = rep_vend;
        r0.attr_id      = rep_id;
        r0.attr_length  = rep_len;
        r0.value_offset = 16'(bp_nxt + 16'd1);
        if (br_nxt < 16'd2) begin
          r1.kind     = KIND_OK;
          r1.run_last = 1'b1;
          n           = 2'd2;
          ph_nxt      = PH_DONE;
        end else begin
          r0.run_last = 1'b1;
          n           = 2'd1;
          idx_nxt     = (alen_nxt == rep_skip) ? 8'd0 : rep_skip;
        end
      end
    end
  end

  assign push.cnt  = n;
  assign push.res0 = r0;
  assign push.res1 = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r   <= '0;
      tl_r   <= '0;
      br_r   <= '0;
      ph_r   <= PH_IDLE;
      idx_r  <= '0;
      aid_r  <= '0;
      alen_r <= '0;
      vacc_r <= '0;
      sid_r  <= '0;
    end else begin
      bp_r   <= bp_nxt;
      tl_r   <= tl_nxt;
      br_r   <= br_nxt;
      ph_r   <= ph_nxt;
      idx_r  <= idx_nxt;
      aid_r  <= aid_nxt;
      alen_r <= alen_nxt;
      vacc_r <= vacc_nxt;
      sid_r  <= sid_nxt;
    end
  end

endmodule

// File: rtl/core/raw_res_fifo.sv
// Four-entry result queue taking up to two results per cycle.
module raw_res_fifo
  import raw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  raw_push_t  push,
  output logic       room,
  raw_out_if.source  out_ch
);

  raw_res_t   mem [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;
  raw_res_t   head;

  assign room = (cnt_r <= 3'd2);
  assign pop  = out_ch.valid && out_ch.ready;
  assign head = mem[rd_ptr_r];

  assign out_ch.valid        = (cnt_r != 3'd0);
  assign out_ch.kind         = head.kind;
  assign out_ch.vendor_id    = head.vendor_id;
  assign out_ch.attr_id      = head.attr_id;
  assign out_ch.attr_length  = head.attr_length;
  assign out_ch.value_offset = head.value_offset;
  assign out_ch.run_last     = head.run_last;

  assign wr_ptr_nxt = 2'(wr_ptr_r + push.cnt);
  assign rd_ptr_nxt = 2'(rd_ptr_r + {1'b0, pop});
  assign cnt_nxt    = 3'(cnt_r + {1'b0, push.cnt} - {2'b00, pop});

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem[2'(wr_ptr_r + 2'd1)] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: verif/raw_attr_checker.sv
// Scoreboard for the RADIUS attribute walker: predicts each byte's results and checks them.
module raw_attr_checker
  import raw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  raw_in_if    mon_in,
  raw_out_if   mon_out,
  output int   fail_count,
  output int   pending_count
);

  typedef enum logic [1:0] {WALK_IDLE, WALK_HEADER, WALK_ATTRS, WALK_DONE} walk_phase_t;

  // Header byte positions of the total length.
  localparam logic [15:0] LEN_HI_POS = 16'd2;
  localparam logic [15:0] LEN_LO_POS = 16'd3;

  // Byte positions inside one TLV.
  localparam logic [7:0] TLV_ID_IDX     = 8'd0;
  localparam logic [7:0] TLV_LEN_IDX    = 8'd1;
  localparam logic [7:0] VEND_FIRST_IDX = 8'd2;
  localparam logic [7:0] VEND_LAST_IDX  = 8'd5;
  localparam logic [7:0] SUB_ID_IDX     = 8'd6;
  localparam logic [7:0] SUB_LEN_IDX    = 8'd7;

  localparam logic [7:0] MIN_TLV_LEN = 8'd2;
  localparam logic [7:0] VSA_HDR_LEN = 8'd6;
  localparam logic [7:0] VSA_MIN_LEN = 8'd8;

  walk_phase_t phase = WALK_IDLE;
  logic [15:0] pkt_pos, pkt_len, len_left;
  logic [7:0]  tlv_idx, tlv_id, tlv_len, sub_id;
  logic [31:0] vendor_acc;
  raw_res_t    step_results[$];
  raw_res_t    expected_results[$];
  int          errors = 0;

  function automatic raw_res_t make_result(logic [1:0] kind, logic [31:0] vend,
                                           logic [7:0] id, logic [7:0] len,
                                           logic [15:0] off);
    raw_res_t r;
    r.kind         = kind;
    r.vendor_id    = vend;
    r.attr_id      = id;
    r.attr_length  = len;
    r.value_offset = off;
    r.run_last     = 1'b0;
    return r;
  endfunction

  task automatic clear_walk();
    pkt_pos    = '0;
    pkt_len    = '0;
    len_left   = '0;
    phase      = WALK_IDLE;
    tlv_idx    = '0;
    tlv_id     = '0;
    tlv_len    = '0;
    vendor_acc = '0;
    sub_id     = '0;
  endtask

  // Report the attribute, then close the packet if fewer than two bytes are left.
  task automatic report_tlv(logic [31:0] vend, logic [7:0] id, logic [7:0] len,
                            logic [7:0] skip_to);
    step_results.push_back(make_result(KIND_ATTR, vend, id, len, pkt_pos + 16'd1));
    if (len_left < 16'(MIN_TLV_LEN)) begin
      step_results.push_back(make_result(KIND_OK, '0, '0, '0, '0));
      phase = WALK_DONE;
    end else if (tlv_len == skip_to) begin
      tlv_idx = TLV_ID_IDX;
    end else begin
      tlv_idx = skip_to;
    end
  endtask

  task automatic walk_tlv_byte(logic [7:0] b);
    logic vsa;
    logic bad;
    vsa = (tlv_id == VSA_ID);
    bad = 1'b0;
    if (tlv_idx == TLV_ID_IDX) begin
      tlv_id  = b;
      tlv_idx = TLV_LEN_IDX;
    end else if (tlv_idx == TLV_LEN_IDX) begin
      tlv_len = b;
      if (len_left < 16'(b) || b < MIN_TLV_LEN) begin
        bad = 1'b1;
      end else begin
        len_left = len_left - 16'(b);
        if (!vsa) begin
          report_tlv(32'd0, tlv_id, b, MIN_TLV_LEN);
        end else if (b < VSA_MIN_LEN) begin
          bad = 1'b1;
        end else begin
          vendor_acc = '0;
          tlv_idx    = VEND_FIRST_IDX;
        end
      end
    end else if (vsa && tlv_idx <= SUB_LEN_IDX) begin
      if (tlv_idx <= VEND_LAST_IDX) begin
        vendor_acc = {vendor_acc[23:0], b};
        tlv_idx    = tlv_idx + 8'd1;
      end else if (tlv_idx == SUB_ID_IDX) begin
        sub_id  = b;
        tlv_idx = SUB_LEN_IDX;
      end else if (b != tlv_len - VSA_HDR_LEN) begin
        bad = 1'b1;
      end else begin
        report_tlv(vendor_acc, sub_id, b, VSA_MIN_LEN);
      end
    end else if (9'(tlv_idx) + 9'd1 >= 9'(tlv_len)) begin
      tlv_idx = TLV_ID_IDX;
    end else begin
      tlv_idx = tlv_idx + 8'd1;
    end
    if (bad) begin
      step_results.push_back(make_result(KIND_BAD, '0, '0, '0, '0));
      phase = WALK_DONE;
    end
  endtask

  task automatic walk_byte(logic [7:0] b, logic first);
    raw_res_t last;
    step_results.delete();
    if (first) begin
      clear_walk();
      phase = WALK_HEADER;
    end else if (phase == WALK_IDLE || phase == WALK_DONE) begin
      return;
    end else begin
      pkt_pos = pkt_pos + 16'd1;
    end
    if (phase == WALK_HEADER) begin
      if (pkt_pos == LEN_HI_POS) begin
        pkt_len = {b, 8'h00};
      end else if (pkt_pos == LEN_LO_POS) begin
        pkt_len[7:0] = b;
        if (pkt_len < HDR_LEN) begin
          step_results.push_back(make_result(KIND_BAD, '0, '0, '0, '0));
          phase = WALK_DONE;
        end
      end else if (pkt_pos == HDR_LEN - 16'd1) begin
        len_left = pkt_len - HDR_LEN;
        if (len_left < 16'(MIN_TLV_LEN)) begin
          step_results.push_back(make_result(KIND_OK, '0, '0, '0, '0));
          phase = WALK_DONE;
        end else begin
          phase   = WALK_ATTRS;
          tlv_idx = TLV_ID_IDX;
        end
      end
    end else begin
      walk_tlv_byte(b);
    end
    if (step_results.size() > 0) begin
      last = step_results.pop_back();
      last.run_last = 1'b1;
      step_results.push_back(last);
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : score
    raw_res_t want;
    int       bad;
    if (!rst_n) begin
      clear_walk();
      expected_results.delete();
    end else begin
      // Results pass the input register and the result queue after their byte: check before predicting.
      if (mon_out.valid && mon_out.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none, got kind %0h vendor %0h id %0h len %0h off %0h",
                   $time, mon_out.kind, mon_out.vendor_id, mon_out.attr_id,
                   mon_out.attr_length, mon_out.value_offset);
          errors++;
        end else begin
          want = expected_results.pop_front();
          bad  = field_bad("kind", 32'(want.kind), 32'(mon_out.kind))
               + field_bad("vendor_id", want.vendor_id, mon_out.vendor_id)
               + field_bad("attr_id", 32'(want.attr_id), 32'(mon_out.attr_id))
               + field_bad("attr_length", 32'(want.attr_length), 32'(mon_out.attr_length))
               + field_bad("value_offset", 32'(want.value_offset), 32'(mon_out.value_offset))
               + field_bad("run_last", 32'(want.run_last), 32'(mon_out.run_last));
          if (bad != 0) errors++;
        end
      end
      if (mon_in.valid && mon_in.ready) walk_byte(mon_in.data_byte, mon_in.first_byte);
    end
    fail_count    <= errors;
    pending_count <= expected_results.size();
  end

endmodule

// File: verif/radius_attribute_walker_tb.sv
// Testbench top for the RADIUS attribute walker: packet stimulus, pacing, watchdog and verdict.
module radius_attribute_walker_tb
  import raw_pkg::*;
();

  localparam int RANDOM_BYTES = 1800;
  // The idle limit is far above any single send gap or result stall;
  // back-to-back stalls make longer quiet runs only rarely.
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int VSA_HDR      = 6;
  localparam int VSA_MIN      = 8;
  localparam int TLV_MIN      = 2;

  logic       clk   = 1'b0;
  logic       rst_n = 1'b0;
  int         fail_count;
  int         pending_count;
  int         idle_cycles       = 0;
  int         burst_left        = 0;
  int         random_bytes_sent = 0;
  int         packets_sent      = 0;
  logic [7:0] pkt_bytes[$];

  raw_in_if  in_ch();
  raw_out_if out_ch();

  radius_attribute_walker uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  raw_attr_checker result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .mon_in       (in_ch),
    .mon_out      (out_ch),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always #5 clk = ~clk;

  // Receiver: each stretch is randomly either free-running or full of random stalls.
  initial begin
    int   stall_left;
    int   mode_left;
    logic stalls_on;
    stall_left = 0;
    mode_left  = 0;
    stalls_on  = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stalls_on = ($urandom_range(0, 2) != 0);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one beat; open a new burst after a random gap when the last one ran out.
  task automatic send_byte(logic [7:0] b, logic first);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.first_byte <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_packet(int n_send, logic with_first);
    for (int i = 0; i < n_send; i++) send_byte(pkt_bytes[i], with_first && i == 0);
  endtask

  // Random header with the total length in bytes 2 and 3.
  task automatic fill_header(int total);
    pkt_bytes.delete();
    repeat (HDR_LEN) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    pkt_bytes[2] = total[15:8];
    pkt_bytes[3] = total[7:0];
  endtask

  function automatic int pick_len(int min_len);
    if ($urandom_range(0, 15) == 0) return $urandom_range(min_len, 255);
    return $urandom_range(min_len, min_len + 10);
  endfunction

  task automatic run_random_packet();
    logic [7:0]  body[$];
    logic [31:0] vend;
    logic [7:0]  id;
    int          n_tlv, tlv_len, sub_len_at, flavor, total, n_send;
    sub_len_at = -1;
    n_tlv = $urandom_range(0, 5);
    for (int i = 0; i < n_tlv; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        tlv_len = pick_len(VSA_MIN);
        vend    = $urandom();
        body.push_back(VSA_ID);
        body.push_back(8'(tlv_len));
        body.push_back(vend[31:24]);
        body.push_back(vend[23:16]);
        body.push_back(vend[15:8]);
        body.push_back(vend[7:0]);
        body.push_back(8'($urandom_range(0, 255)));
        if (sub_len_at < 0) sub_len_at = body.size();
        body.push_back(8'(tlv_len - VSA_HDR));
        repeat (tlv_len - VSA_MIN) body.push_back(8'($urandom_range(0, 255)));
      end else begin
        tlv_len = pick_len(TLV_MIN);
        do id = 8'($urandom_range(0, 255)); while (id == VSA_ID);
        body.push_back(id);
        body.push_back(8'(tlv_len));
        repeat (tlv_len - TLV_MIN) body.push_back(8'($urandom_range(0, 255)));
      end
    end
    // One spare byte at the tail still ends the packet ok.
    if ($urandom_range(0, 1) == 1) body.push_back(8'($urandom_range(0, 255)));
    total  = HDR_LEN + body.size();
    n_send = total;
    flavor = $urandom_range(0, 99);
    if (flavor < 55) begin
      // well formed
    end else if (flavor < 63) begin
      total = $urandom_range(0, HDR_LEN - 1);
    end else if (flavor < 71) begin
      // shrink the total so the walk overruns or stops early
      if (body.size() > 0) total = total - $urandom_range(1, body.size());
    end else if (flavor < 77) begin
      if (body.size() > 1) body[1] = 8'($urandom_range(0, VSA_MIN - 1));
    end else if (flavor < 83) begin
      if (sub_len_at >= 0) body[sub_len_at] = body[sub_len_at] + 8'($urandom_range(1, 255));
    end else if (flavor < 91) begin
      n_send = $urandom_range(1, total - 1);
    end else if (flavor < 96) begin
      // claim more than is sent; the next packet abandons this one
      total = $urandom_range(total + 2, 65535);
    end
    fill_header(total);
    foreach (body[i]) pkt_bytes.push_back(body[i]);
    if (flavor >= 96) begin
      repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      n_send = pkt_bytes.size();
    end
    send_packet(n_send, 1'b1);
    random_bytes_sent += n_send;
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.first_byte = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Bytes before any packet start are dropped.
    pkt_bytes = '{8'hFF, 8'h00};
    send_packet(2, 1'b0);
    // Total length below the header, then a byte after the error.
    pkt_bytes = '{8'h01, 8'hFF, 8'h00, 8'h13, 8'hA5};
    send_packet(5, 1'b1);
    // Header with a single spare byte: ok on the last header byte.
    fill_header(HDR_LEN + 1);
    pkt_bytes.push_back(8'h00);
    send_packet(HDR_LEN + 1, 1'b1);

    while (random_bytes_sent < RANDOM_BYTES) begin
      run_random_packet();
      packets_sent++;
      // Now and then hold off until every result is out.
      if (packets_sent % 10 == 0) begin
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
